[rtl/core/mbmc_pkg.sv]
package mbmc_pkg;

    // mode codes, shared by request and status
    localparam logic [2:0] MODE_SLEEP = 3'd0;
    localparam logic [2:0] MODE_WAKE  = 3'd1;
    localparam logic [2:0] MODE_FWD   = 3'd2;
    localparam logic [2:0] MODE_REV   = 3'd3;
    localparam logic [2:0] MODE_BRAKE = 3'd4;
    localparam logic [2:0] MODE_STOP  = 3'd5;

    // request type codes on the input channel
    localparam logic [1:0] REQ_MODE   = 2'd0;
    localparam logic [1:0] REQ_SAMPLE = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_WAKE      = 2'd1;
    localparam logic [1:0] CFG_DEADTIME  = 2'd2;

    localparam int unsigned CFG_DW = 12;
    localparam int unsigned CFG_IW = 2;

    // mv = raw * 3300 / 4095 = raw * 220 / 273, done as raw * (220 * ceil(2^29 / 273)) >> 29,
    // exact for every 12-bit count
    localparam int unsigned       MV_SHIFT = 29;
    localparam int unsigned       MV_PW    = 41;
    localparam logic [MV_SHIFT-1:0] MV_RECIP = 29'd432643420;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_NOP    = 2'd0,
        OP_MODE   = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STEP_IDLE = 3'b001,
        STEP_WAKE = 3'b010,
        STEP_DEAD = 3'b100
    } step_t;

    // classified transaction handed from front to back
    typedef struct packed {
        op_t         op;
        logic [2:0]  mode;
        logic [11:0] mv;
        logic        flt;
    } cmd_t;

    typedef struct packed {
        logic [11:0] threshold;
        logic [7:0]  wake_ticks;
        logic [7:0]  dead_ticks;
    } cfg_t;

    typedef struct packed {
        logic        sleep_n;
        logic        enable;
        logic        phase;
        logic [2:0]  mode;
        logic [11:0] current_mv;
        logic        overcurrent;
        logic        fault;
        logic        busy;
        logic        refused;
    } res_t;

endpackage

[rtl/core/mbmc_front.sv]
module mbmc_front (
    input  logic [1:0]     req_type,
    input  logic [2:0]     req_mode,
    input  logic [11:0]    current_raw,
    input  logic           fault_pin_low,
    output mbmc_pkg::cmd_t cmd
);
    import mbmc_pkg::*;

    logic [MV_PW-1:0] prod;

    // constant-reciprocal scaling of the ADC count
    assign prod = MV_PW'(current_raw) * MV_PW'(MV_RECIP);

    always_comb begin
        cmd.mode = req_mode;
        cmd.mv   = prod[MV_PW-1:MV_SHIFT];
        cmd.flt  = fault_pin_low;
        unique case (req_type)
            // every mode code goes back: a busy sequencer refuses even junk codes
            REQ_MODE:   cmd.op = OP_MODE;
            REQ_SAMPLE: cmd.op = OP_SAMPLE;
            REQ_TICK:   cmd.op = OP_TICK;
            default:    cmd.op = OP_NOP;
        endcase
    end

endmodule

[rtl/core/mbmc_queue.sv]
module mbmc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  mbmc_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output mbmc_pkg::cmd_t head_data
);
    import mbmc_pkg::*;

    cmd_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;
    logic           do_push, do_pop;

    assign full       = (count_reg == QCW'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/mbmc_back.sv]
module mbmc_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  mbmc_pkg::cfg_t cfg,
    input  logic           cmd_valid,
    input  mbmc_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           res_valid,
    output mbmc_pkg::res_t res,
    input  logic           res_ready
);
    import mbmc_pkg::*;

    logic [2:0]  mode_reg, mode_next;
    logic [2:0]  pins_reg, pins_next;      // {sleep_n, enable, phase}
    logic [11:0] cur_reg, cur_next;
    logic        latch_reg, latch_next;
    logic        fault_reg, fault_next;
    logic [7:0]  count_reg, count_next;
    step_t       step_reg, step_next;
    logic [2:0]  pmode_reg, pmode_next;
    logic        valid_reg, valid_next;
    res_t        res_reg, res_next;

    logic        refused;
    logic        fin;
    logic        start;
    step_t       start_step;
    logic [7:0]  start_ticks;
    logic [7:0]  dec;
    logic        running;

    assign cmd_pop   = cmd_valid && (!valid_reg || res_ready);
    assign res_valid = valid_reg;
    assign res       = res_reg;
    assign running   = (mode_reg == MODE_FWD) || (mode_reg == MODE_REV);
    assign dec       = (count_reg != '0) ? count_reg - 1'b1 : '0;

    always_comb begin
        mode_next   = mode_reg;
        pins_next   = pins_reg;
        cur_next    = cur_reg;
        latch_next  = latch_reg;
        fault_next  = fault_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        pmode_next  = pmode_reg;
        refused     = 1'b0;
        fin         = 1'b0;
        start       = 1'b0;
        start_step  = STEP_WAKE;
        start_ticks = cfg.wake_ticks;

        unique case (cmd.op)
            OP_MODE: begin
                if (step_reg != STEP_IDLE) begin
                    refused = 1'b1;
                end else if (cmd.mode > MODE_STOP) begin
                    // codes six and seven do nothing
                end else begin
                    priority if (cmd.mode == MODE_SLEEP) begin
                        pins_next  = 3'b000;
                        mode_next  = MODE_SLEEP;
                        cur_next   = '0;
                        fault_next = cmd.flt;
                    end else if (cmd.mode == MODE_WAKE) begin
                        pins_next = 3'b100;
                        start     = 1'b1;
                    end else if (cmd.mode == MODE_BRAKE || cmd.mode == MODE_STOP) begin
                        pins_next  = 3'b100;
                        mode_next  = cmd.mode;
                        cur_next   = '0;
                        latch_next = 1'b0;
                        fault_next = cmd.flt;
                    end else if (mode_reg == MODE_SLEEP) begin
                        pins_next = 3'b100;
                        start     = 1'b1;
                    end else if (running && mode_reg != cmd.mode) begin
                        // reversal: drop enable, hold off for the dead time
                        pins_next   = {pins_reg[2], 1'b0, pins_reg[0]};
                        start       = 1'b1;
                        start_step  = STEP_DEAD;
                        start_ticks = cfg.dead_ticks;
                    end else begin
                        pins_next  = {2'b11, cmd.mode == MODE_FWD};
                        mode_next  = cmd.mode;
                        cur_next   = '0;
                        fault_next = cmd.flt;
                    end
                end
            end
            OP_SAMPLE: begin
                if (step_reg == STEP_IDLE && running) begin
                    cur_next   = cmd.mv;
                    fault_next = cmd.flt;
                    if (cmd.mv >= cfg.threshold) begin
                        pins_next  = {2'b10, pins_reg[0]};
                        mode_next  = MODE_BRAKE;
                        latch_next = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                if (step_reg != STEP_IDLE) begin
                    count_next = dec;
                    fin        = (dec == '0);
                end
            end
            default: ;
        endcase

        if (start) begin
            pmode_next = cmd.mode;
            step_next  = start_step;
            if (start_ticks == '0) begin
                fin = 1'b1;
            end else begin
                count_next = start_ticks;
            end
        end

        // delay done: apply the held mode
        if (fin) begin
            step_next  = STEP_IDLE;
            count_next = '0;
            cur_next   = '0;
            fault_next = cmd.flt;
            if (pmode_next == MODE_WAKE) begin
                mode_next  = MODE_WAKE;
                latch_next = 1'b0;
            end else begin
                pins_next = {2'b11, pmode_next == MODE_FWD};
                mode_next = pmode_next;
            end
        end

        res_next.sleep_n     = pins_next[2];
        res_next.enable      = pins_next[1];
        res_next.phase       = pins_next[0];
        res_next.mode        = mode_next;
        res_next.current_mv  = cur_next;
        res_next.overcurrent = latch_next;
        res_next.fault       = fault_next;
        res_next.busy        = (step_next != STEP_IDLE);
        res_next.refused     = refused;

        valid_next = cmd_pop ? 1'b1 : (valid_reg && !res_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_SLEEP;
            pins_reg  <= '0;
            cur_reg   <= '0;
            latch_reg <= 1'b0;
            fault_reg <= 1'b0;
            count_reg <= '0;
            step_reg  <= STEP_IDLE;
            pmode_reg <= MODE_SLEEP;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cmd_pop) begin
                mode_reg  <= mode_next;
                pins_reg  <= pins_next;
                cur_reg   <= cur_next;
                latch_reg <= latch_next;
                fault_reg <= fault_next;
                count_reg <= count_next;
                step_reg  <= step_next;
                pmode_reg <= pmode_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            res_reg <= res_next;
        end
    end

endmodule

[rtl/core/motor_bridge_mode_controller.sv]
// H-bridge mode controller for a phase/enable driver. Each input transaction
// is a mode request, a current sample or a one-millisecond tick, and each
// produces exactly one result transaction carrying the pin levels, stored
// mode, last current in mV, overcurrent latch, sampled fault, busy and
// refused flags. Throughput is one transaction per clock while the result
// channel is not stalled; an accepted input is queued before its result is
// registered (front classification and current scaling are combinational and
// land in a two-entry queue at the accepting edge, then the mode sequencer
// pops it and loads the result register when free). The sequencer updates
// all state once per transaction. A stalled result channel fills the queue
// and then drops s_ready. Configuration writes take effect on the next clock
// and must be made while no transaction is in flight. Overcurrent threshold,
// wake delay and dead time reset to 3000 mV, 5 ticks and 20 ticks.
module motor_bridge_mode_controller (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic [mbmc_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [mbmc_pkg::CFG_DW-1:0]   cfg_wr_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_req_type,
    input  logic [2:0]                    s_req_mode,
    input  logic [11:0]                   s_current_raw,
    input  logic                          s_fault_pin_low,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_sleep_n_pin,
    output logic                          m_bridge_enable_pin,
    output logic                          m_phase_pin,
    output logic [2:0]                    m_motor_mode,
    output logic [11:0]                   m_motor_current_mv,
    output logic                          m_overcurrent_flag,
    output logic                          m_driver_fault,
    output logic                          m_busy_res,
    output logic                          m_request_refused
);
    import mbmc_pkg::*;

    // configuration registers
    cfg_t cfg_reg, cfg_next;

    // front -> queue -> back
    cmd_t front_cmd;
    cmd_t head_cmd;
    logic q_full;
    logic q_valid;
    logic q_pop;
    res_t res;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_THRESHOLD: cfg_next.threshold  = cfg_wr_data;
                CFG_WAKE:      cfg_next.wake_ticks = cfg_wr_data[7:0];
                CFG_DEADTIME:  cfg_next.dead_ticks = cfg_wr_data[7:0];
                default: ;     // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold  <= 12'd3000;
            cfg_reg.wake_ticks <= 8'd5;
            cfg_reg.dead_ticks <= 8'd20;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: classify the transaction and scale the ADC count
    mbmc_front u_front (
        .req_type      (s_req_type),
        .req_mode      (s_req_mode),
        .current_raw   (s_current_raw),
        .fault_pin_low (s_fault_pin_low),
        .cmd           (front_cmd)
    );

    // input is taken whenever the queue has a free slot
    assign s_ready = !q_full;

    mbmc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid),
        .push_data  (front_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (head_cmd)
    );

    // back end: mode sequencer, delays, overcurrent check, result register
    mbmc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (q_valid),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .res_valid (m_valid),
        .res       (res),
        .res_ready (m_ready)
    );

    assign m_sleep_n_pin       = res.sleep_n;
    assign m_bridge_enable_pin = res.enable;
    assign m_phase_pin         = res.phase;
    assign m_motor_mode        = res.mode;
    assign m_motor_current_mv  = res.current_mv;
    assign m_overcurrent_flag  = res.overcurrent;
    assign m_driver_fault      = res.fault;
    assign m_busy_res          = res.busy;
    assign m_request_refused   = res.refused;

endmodule
